// ===== hdl/tlrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrc_pkg
// shared types and codes of the tile layer residency cache
// ----------------------------------------------------------------------------
package tlrc_pkg;

	localparam int KEY_W   = 53;
	localparam int LAYER_W = 7;
	localparam int TOUCH_W = 32;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 16;

	localparam logic [LAYER_W-1:0] NO_LAYER = 7'd127;

	localparam logic [1:0] RDY_PENDING  = 2'd0;
	localparam logic [1:0] RDY_RESIDENT = 2'd1;
	localparam logic [1:0] RDY_HOLE     = 2'd2;

	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_VISIT = 1'b1;

	localparam logic [1:0] FR_PENDING = 2'd0;
	localparam logic [1:0] FR_READY   = 2'd1;

	localparam logic [2:0] OC_RESIDENT  = 3'd0;
	localparam logic [2:0] OC_HOLE      = 3'd1;
	localparam logic [2:0] OC_NO_BUDGET = 3'd2;
	localparam logic [2:0] OC_PENDING   = 3'd3;
	localparam logic [2:0] OC_LOADED    = 3'd4;
	localparam logic [2:0] OC_NO_LAYER  = 3'd5;
	localparam logic [2:0] OC_FAILED    = 3'd6;
	localparam logic [2:0] OC_FULL      = 3'd7;

	localparam logic [1:0] REG_BUDGET = 2'd0;
	localparam logic [1:0] REG_FORGET = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	typedef struct packed {
		logic        action;
		logic [4:0]  zoom;
		logic [23:0] tile_x;
		logic [23:0] tile_y;
		logic [1:0]  fetch_result;
	} in_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic [5:0] layer;
		logic       upload_request;
		logic       fetch_request;
		logic [1:0] sheet_state;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [LAYER_W-1:0] layer;
		logic [1:0]         ready;
		logic [TOUCH_W-1:0] touch;
	} entry_t;

endpackage

// ===== hdl/tlrc_mem.sv =====
// ----------------------------------------------------------------------------
// tlrc_mem
// entry store: one write port, one registered read port
// ----------------------------------------------------------------------------
module tlrc_mem #(
	parameter int ENTRIES = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  tlrc_pkg::entry_t           wdata,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output tlrc_pkg::entry_t           rdata
);

	tlrc_pkg::entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/tile_layer_residency_cache_unit.sv =====
// ----------------------------------------------------------------------------
// tile_layer_residency_cache_unit
// maps tile keys to texture layers with per-frame fetch budget and lru reuse
// ----------------------------------------------------------------------------
//  channel  | signals                         | moves
//  ---------+---------------------------------+------------------------------
//  in       | in_valid in_ready in_data       | frame start or visit request
//  out      | out_valid out_ready out_data    | one result per request
//  cfg      | cfg_we cfg_index cfg_wdata      | register write, no wait
//
// a request is taken only in idle; the scan reads every entry, one read per cycle,
// through the registered memory read port, and a finish step then forms the result
// the block returns to idle after the finish and takes the next request from there
// reset clears valid bits, frame count, layer pool and counters at once
// a result waits in the output register; the next request is taken meanwhile
// and holds in its finish cycle while the previous result is not taken
// ----------------------------------------------------------------------------
module tile_layer_residency_cache_unit #(
	parameter int LAYERS  = 64,
	parameter int ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tlrc_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tlrc_pkg::out_t               out_data,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [tlrc_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int AW = $clog2(ENTRIES);
	localparam int LW = tlrc_pkg::LAYER_W;
	localparam int TW = tlrc_pkg::TOUCH_W;
	localparam int CW = tlrc_pkg::CNT_W;
	localparam logic [AW:0]   ENT_END  = (AW+1)'(ENTRIES);
	localparam logic [LW-1:0] LAYER_LIM = LW'(LAYERS);
	localparam logic [CW-1:0] CNT_MAX  = '1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0]    budget_q;
	logic [15:0]   forget_q;
	logic          enable_q;

	// global state
	logic [ENTRIES-1:0] valid_q;
	logic [TW-1:0]      frame_q;
	logic [LW-1:0]      handed_q;
	logic [3:0]         fetches_q;
	logic [CW-1:0]      wanted_q, resident_q, holes_q;

	// request held during the pass
	tlrc_pkg::in_t      req_q;
	logic [AW:0]        cnt_q;
	logic               rd_s1;
	logic [AW-1:0]      idx_s1;

	// scan findings
	logic               found_q, free_found_q, vic_found_q;
	logic [AW-1:0]      slot_q, free_q, vic_q;
	logic [LW-1:0]      slot_layer_q, vic_layer_q;
	logic [1:0]         slot_ready_q;
	logic [TW-1:0]      vic_touch_q;

	// output register
	logic               out_valid_q;
	tlrc_pkg::out_t     out_q;

	// memory ports
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr;
	tlrc_pkg::entry_t   mem_wdata, mem_rdata;
	logic [tlrc_pkg::KEY_W-1:0] req_key;

	assign req_key   = {req_q.zoom, req_q.tile_x, req_q.tile_y};
	assign mem_re    = (state_q == ST_SCAN) && (cnt_q != ENT_END);

	tlrc_mem #(.ENTRIES(ENTRIES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// finish step: decide the visit outcome and the write-back
	logic           fin_go;
	tlrc_pkg::out_t fin_out;
	logic [AW-1:0]  fin_slot;
	logic [LW-1:0]  fin_layer;
	logic [1:0]     fin_ready;
	logic           fin_write, fin_take_pool, fin_take_vic, fin_fetch;
	logic           bump_w, bump_r, bump_h;
	logic [CW-1:0]  nw, nr, nh;

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		logic [LW-1:0] cur_layer;
		logic [1:0]    cur_ready;
		logic [LW-1:0] got;
		fin_out       = '0;
		fin_slot      = found_q ? slot_q : free_q;
		cur_layer     = found_q ? slot_layer_q : tlrc_pkg::NO_LAYER;
		cur_ready     = found_q ? slot_ready_q : tlrc_pkg::RDY_PENDING;
		fin_layer     = cur_layer;
		fin_ready     = cur_ready;
		fin_write     = 1'b0;
		fin_take_pool = 1'b0;
		fin_take_vic  = 1'b0;
		fin_fetch     = 1'b0;
		bump_w        = 1'b0;
		bump_r        = 1'b0;
		bump_h        = 1'b0;
		got           = tlrc_pkg::NO_LAYER;
		if (req_q.action == tlrc_pkg::ACT_VISIT) begin
			bump_w = 1'b1;
			if (!found_q && !free_found_q) begin
				fin_out.outcome = tlrc_pkg::OC_FULL;
			end else begin
				fin_write = 1'b1;
				if (cur_ready == tlrc_pkg::RDY_RESIDENT) begin
					bump_r          = 1'b1;
					fin_out.outcome = tlrc_pkg::OC_RESIDENT;
					fin_out.layer   = cur_layer[5:0];
				end else if (cur_ready == tlrc_pkg::RDY_HOLE) begin
					bump_h          = 1'b1;
					fin_out.outcome = tlrc_pkg::OC_HOLE;
				end else if (!enable_q || fetches_q >= budget_q) begin
					fin_out.outcome = tlrc_pkg::OC_NO_BUDGET;
				end else begin
					fin_fetch             = 1'b1;
					fin_out.fetch_request = 1'b1;
					if (req_q.fetch_result[1]) begin
						fin_ready       = tlrc_pkg::RDY_HOLE;
						bump_h          = 1'b1;
						fin_out.outcome = tlrc_pkg::OC_FAILED;
					end else if (req_q.fetch_result == tlrc_pkg::FR_PENDING) begin
						fin_out.outcome = tlrc_pkg::OC_PENDING;
					end else begin
						if (handed_q < LAYER_LIM) begin
							fin_take_pool = 1'b1;
							got           = handed_q;
						end else if (vic_found_q) begin
							fin_take_vic = 1'b1;
							got          = vic_layer_q;
						end
						if (fin_take_pool || fin_take_vic) begin
							fin_layer              = got;
							fin_ready              = tlrc_pkg::RDY_RESIDENT;
							bump_r                 = 1'b1;
							fin_out.outcome        = tlrc_pkg::OC_LOADED;
							fin_out.layer          = got[5:0];
							fin_out.upload_request = 1'b1;
						end else begin
							fin_out.outcome = tlrc_pkg::OC_NO_LAYER;
						end
					end
				end
			end
		end
		nw = (bump_w && wanted_q   != CNT_MAX) ? wanted_q   + 1'b1 : wanted_q;
		nr = (bump_r && resident_q != CNT_MAX) ? resident_q + 1'b1 : resident_q;
		nh = (bump_h && holes_q    != CNT_MAX) ? holes_q    + 1'b1 : holes_q;
		// sheet state from the updated counters
		if (nw == '0)       fin_out.sheet_state = 2'd0;
		else if (nr >= nw)  fin_out.sheet_state = 2'd3;
		else if (nr != '0)  fin_out.sheet_state = 2'd2;
		else if (nh >= nw)  fin_out.sheet_state = 2'd1;
		else                fin_out.sheet_state = 2'd0;
	end

	assign mem_we    = fin_go && fin_write;
	assign mem_waddr = fin_slot;
	assign mem_wdata = {req_key, fin_layer, fin_ready, frame_q};

	// scan element view
	logic ent_v, key_hit, vic_ok;
	logic [TW-1:0] age;
	assign ent_v   = rd_s1 && valid_q[idx_s1];
	assign key_hit = ent_v && (mem_rdata.key == req_key);
	assign age     = frame_q - mem_rdata.touch;
	assign vic_ok  = ent_v && !key_hit && (mem_rdata.layer != tlrc_pkg::NO_LAYER)
		&& (mem_rdata.touch != frame_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			budget_q     <= 4'd4;
			forget_q     <= 16'd120;
			enable_q     <= 1'b1;
			valid_q      <= '0;
			frame_q      <= '0;
			handed_q     <= '0;
			fetches_q    <= '0;
			wanted_q     <= '0;
			resident_q   <= '0;
			holes_q      <= '0;
			cnt_q        <= '0;
			rd_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tlrc_pkg::REG_BUDGET: budget_q <= cfg_wdata[3:0];
					tlrc_pkg::REG_FORGET: forget_q <= cfg_wdata;
					tlrc_pkg::REG_ENABLE: enable_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			rd_s1  <= mem_re;
			idx_s1 <= cnt_q[AW-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q        <= in_data;
						cnt_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						vic_found_q  <= 1'b0;
						state_q      <= ST_SCAN;
						if (in_data.action == tlrc_pkg::ACT_FRAME) begin
							frame_q    <= frame_q + 1'b1;
							fetches_q  <= '0;
							wanted_q   <= '0;
							resident_q <= '0;
							holes_q    <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!rd_s1) begin
						state_q <= ST_FIN;
					end
					if (req_q.action == tlrc_pkg::ACT_FRAME) begin
						// purge layerless entries gone untouched too long
						if (ent_v && mem_rdata.layer == tlrc_pkg::NO_LAYER
							&& age > {16'd0, forget_q}) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end else begin
						if (key_hit && !found_q) begin
							found_q      <= 1'b1;
							slot_q       <= idx_s1;
							slot_layer_q <= mem_rdata.layer;
							slot_ready_q <= mem_rdata.ready;
						end
						if (rd_s1 && !valid_q[idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q       <= idx_s1;
						end
						// oldest touch wins, lowest slot on ties
						if (vic_ok && (!vic_found_q || mem_rdata.touch < vic_touch_q)) begin
							vic_found_q <= 1'b1;
							vic_q       <= idx_s1;
							vic_layer_q <= mem_rdata.layer;
							vic_touch_q <= mem_rdata.touch;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						out_q       <= fin_out;
						wanted_q    <= nw;
						resident_q  <= nr;
						holes_q     <= nh;
						if (fin_fetch)     fetches_q <= fetches_q + 1'b1;
						if (fin_take_pool) handed_q  <= handed_q + 1'b1;
						// victim slot drops out, visited slot becomes valid
						if (fin_write) begin
							valid_q <= (valid_q & ~(ENTRIES'(fin_take_vic) << vic_q))
								| (ENTRIES'(1) << fin_slot);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
